/* hdl/bsa_pkg.sv */
package bsa_pkg;

	localparam int ARCHIVE_LIMIT_DEF  = 32;
	localparam int MAX_OBJECTIVES_DEF = 4;
	localparam int MAX_PARAMS_DEF     = 64;

	// Objective index outputs on the result item, whatever MAX_OBJECTIVES is.
	localparam int NUM_OBJ_OUT = 4;

	localparam logic [39:0] SCORE_MAX = 40'hFF_FFFF_FFFF;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	localparam logic [2:0] REG_NUM_OBJ  = 3'd0;
	localparam logic [2:0] REG_NUM_PAR  = 3'd1;
	localparam logic [2:0] REG_WEIGHT_0 = 3'd2;
	localparam logic [2:0] REG_WEIGHT_1 = 3'd3;
	localparam logic [2:0] REG_WEIGHT_2 = 3'd4;
	localparam logic [2:0] REG_WEIGHT_3 = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCORE,
		ST_WRITE,
		ST_WSCAN,
		ST_SHIFT,
		ST_RADDR,
		ST_RDATA,
		ST_RSCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
		logic        [4:0]  entry;
		logic        [6:0]  element;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               read_error;
		logic        [4:0]  best_all;
		logic        [39:0] best_score;
		logic        [4:0]  best_obj_a;
		logic        [4:0]  best_obj_b;
		logic        [4:0]  best_obj_c;
		logic        [4:0]  best_obj_d;
		logic        [4:0]  held;
		logic               removed;
		logic        [4:0]  removed_at;
	} result_t;

endpackage

/* hdl/bounded_scored_archive.sv */
// Bounded archive of scored candidates. A candidate streams in as one load
// item per element: the active objectives, then the parameters. A load that
// does not complete a candidate leaves the block idle and gives no result. The
// completing load, and every read item, gives exactly one result, shown on
// result for the single cycle in which done is high; the receiver cannot
// stall it, and busy stays high until that cycle has passed. A commit clears
// any unused slots, scores the candidate with one multiplier shared across
// the objectives, then makes one pass for the worst entry when the archive is
// full and one for the report, each reading one entry a cycle from the score
// and objective memories; without an eviction the worst-entry pass drops out.
// A read fetches its element, unless it is in error, then makes the report pass. The
// entry order is kept in a small index table, so an eviction reorders
// indices in its shift state instead of moving stored data.
module bounded_scored_archive #(
	parameter int ARCHIVE_LIMIT  = bsa_pkg::ARCHIVE_LIMIT_DEF,
	parameter int MAX_OBJECTIVES = bsa_pkg::MAX_OBJECTIVES_DEF,
	parameter int MAX_PARAMS     = bsa_pkg::MAX_PARAMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  bsa_pkg::cmd_t    cmd,
	output logic             done,
	output bsa_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [15:0]      cfg_data
);

	localparam int SLOTS = MAX_OBJECTIVES + MAX_PARAMS;
	localparam int PW    = $clog2(ARCHIVE_LIMIT);
	localparam int HW    = $clog2(ARCHIVE_LIMIT + 1);
	localparam int SW    = $clog2(SLOTS);
	localparam int AW    = $clog2(ARCHIVE_LIMIT * SLOTS);
	localparam int OIW   = (MAX_OBJECTIVES > 1) ? $clog2(MAX_OBJECTIVES) : 1;
	localparam int OBJW  = 32 * MAX_OBJECTIVES;

	bsa_pkg::state_t state_q, state_d;

	// Configuration.
	logic [2:0]  nobj_q;
	logic [6:0]  npar_q;
	logic [15:0] w_q [4];

	// Control state.
	logic [9:0]  pos_q;
	logic [HW-1:0] held_q;
	logic [PW-1:0] map_q [ARCHIVE_LIMIT];
	logic [9:0]  clr_q;
	logic [2:0]  k_q;
	logic [HW-1:0] scan_i_q;
	logic        v_s1;

	// Payload.
	logic [PW-1:0] phys_q;
	logic [4:0]  e_q;
	logic [SW-1:0] slot_q;
	logic [HW-1:0] idx_s1;
	logic [39:0] ws_q;
	logic [PW-1:0] worst_q;
	logic [39:0] bs_q;
	logic [HW-1:0] best_q;
	logic signed [31:0] bv_q [bsa_pkg::NUM_OBJ_OUT];
	logic [HW-1:0] bo_q [bsa_pkg::NUM_OBJ_OUT];
	logic signed [31:0] obj_q [MAX_OBJECTIVES];
	logic signed [31:0] read_value_q;
	logic        read_error_q;
	logic        removed_q;
	logic [4:0]  removed_at_q;

	// Effective counts.
	logic [2:0]  nobj_e;
	logic [8:0]  npar_e;
	logic [9:0]  total;

	assign nobj_e = (nobj_q == 3'd0) ? 3'd1 :
		((32'(nobj_q) > MAX_OBJECTIVES) ? 3'(MAX_OBJECTIVES) : nobj_q);
	assign npar_e = (npar_q == 7'd0) ? 9'd1 :
		((32'(npar_q) > MAX_PARAMS) ? 9'(MAX_PARAMS) : 9'(npar_q));
	assign total  = 10'(nobj_e) + 10'(npar_e);

	logic accept, ld, rd;
	assign accept = start && !busy;
	assign ld     = accept && (cmd.func == bsa_pkg::FUNC_LOAD);
	assign rd     = accept && (cmd.func == bsa_pkg::FUNC_READ);

	// Load placement.
	logic          ld_is_obj, ld_keep, ld_last;
	logic [9:0]    ld_poff;
	logic [SW-1:0] ld_slot;

	assign ld_is_obj = pos_q < 10'(nobj_e);
	assign ld_poff   = pos_q - 10'(nobj_e);
	assign ld_keep   = ld_is_obj || (ld_poff < 10'(MAX_PARAMS));
	assign ld_slot   = ld_is_obj ? SW'(pos_q) : SW'(10'(MAX_OBJECTIVES) + ld_poff);
	assign ld_last   = (pos_q + 10'd1) >= total;

	// Clearing of unloaded slots: unused objectives, then unused parameters.
	logic [9:0] clr_start, clr_next;
	assign clr_start = (32'(nobj_e) < MAX_OBJECTIVES) ? 10'(nobj_e) :
		10'(MAX_OBJECTIVES) + 10'(npar_e);
	assign clr_next  = (clr_q + 10'd1 == 10'(MAX_OBJECTIVES)) ?
		10'(MAX_OBJECTIVES) + 10'(npar_e) : clr_q + 10'd1;

	// Read checks.
	logic          rd_err;
	logic [SW-1:0] rd_slot;
	assign rd_err  = (32'(cmd.entry) >= 32'(held_q)) || (32'(cmd.entry) >= ARCHIVE_LIMIT) ||
		(10'(cmd.element) >= total);
	assign rd_slot = (10'(cmd.element) < 10'(nobj_e)) ? SW'(cmd.element) :
		SW'(10'(MAX_OBJECTIVES) + 10'(cmd.element) - 10'(nobj_e));

	// Shared index table port.
	logic [PW-1:0] map_idx, map_rd;
	assign map_rd = map_q[map_idx];

	// Scan control.
	logic in_scan, issue, scan_end;
	assign in_scan  = (state_q == bsa_pkg::ST_WSCAN) || (state_q == bsa_pkg::ST_RSCAN);
	assign issue    = in_scan && (scan_i_q < held_q);
	assign scan_end = in_scan && !issue && !v_s1;

	// Memories.
	logic          m_we;
	logic [AW-1:0] m_waddr, m_raddr;
	logic [31:0]   m_wdata, m_rdata;
	logic          s_we;
	logic [39:0]   s_rdata;
	logic [OBJW-1:0] o_wdata, o_rdata;
	logic [39:0]   score;
	logic          mac_en;

	bsa_ram #(.WIDTH(32), .DEPTH(ARCHIVE_LIMIT * SLOTS)) u_store (
		.clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
		.raddr(m_raddr), .rdata(m_rdata)
	);

	bsa_ram #(.WIDTH(40), .DEPTH(ARCHIVE_LIMIT)) u_scores (
		.clk(clk), .we(s_we), .waddr(phys_q), .wdata(score),
		.raddr(map_rd), .rdata(s_rdata)
	);

	bsa_ram #(.WIDTH(OBJW), .DEPTH(ARCHIVE_LIMIT)) u_objs (
		.clk(clk), .we(s_we), .waddr(phys_q), .wdata(o_wdata),
		.raddr(map_rd), .rdata(o_rdata)
	);

	bsa_mac u_mac (
		.clk(clk), .arst_n(arst_n), .clr(state_q == bsa_pkg::ST_IDLE), .en(mac_en),
		.weight(w_q[2'(k_q)]), .operand(obj_q[OIW'(k_q)]), .score(score)
	);

	always_comb begin
		for (int k = 0; k < MAX_OBJECTIVES; k++) begin
			o_wdata[k*32 +: 32] = (k < 32'(nobj_e)) ? obj_q[k] : 32'd0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bsa_pkg::ST_IDLE: begin
				if (ld && ld_last) begin
					state_d = (32'(clr_start) < SLOTS) ? bsa_pkg::ST_CLEAR :
						bsa_pkg::ST_SCORE;
				end else if (rd) begin
					state_d = rd_err ? bsa_pkg::ST_RSCAN : bsa_pkg::ST_RADDR;
				end
			end
			bsa_pkg::ST_CLEAR: begin
				if (32'(clr_next) >= SLOTS) begin
					state_d = bsa_pkg::ST_SCORE;
				end
			end
			bsa_pkg::ST_SCORE: begin
				if (k_q == nobj_e) begin
					state_d = bsa_pkg::ST_WRITE;
				end
			end
			bsa_pkg::ST_WRITE: begin
				state_d = (32'(held_q) + 1 >= ARCHIVE_LIMIT) ? bsa_pkg::ST_WSCAN :
					bsa_pkg::ST_RSCAN;
			end
			bsa_pkg::ST_WSCAN: begin
				if (scan_end) begin
					state_d = bsa_pkg::ST_SHIFT;
				end
			end
			bsa_pkg::ST_SHIFT: state_d = bsa_pkg::ST_RSCAN;
			bsa_pkg::ST_RADDR: state_d = bsa_pkg::ST_RDATA;
			bsa_pkg::ST_RDATA: state_d = bsa_pkg::ST_RSCAN;
			bsa_pkg::ST_RSCAN: begin
				if (scan_end) begin
					state_d = bsa_pkg::ST_DONE;
				end
			end
			bsa_pkg::ST_DONE: state_d = bsa_pkg::ST_IDLE;
			default: state_d = bsa_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		busy    = (state_q != bsa_pkg::ST_IDLE);
		done    = (state_q == bsa_pkg::ST_DONE);
		m_we    = 1'b0;
		m_waddr = AW'(phys_q) * AW'(SLOTS) + AW'(SW'(clr_q));
		m_wdata = 32'd0;
		m_raddr = AW'(map_rd) * AW'(SLOTS) + AW'(slot_q);
		map_idx = PW'(held_q);
		mac_en  = 1'b0;
		s_we    = 1'b0;
		case (state_q)
			bsa_pkg::ST_IDLE: begin
				m_we    = ld && ld_keep;
				m_waddr = AW'(map_rd) * AW'(SLOTS) + AW'(ld_slot);
				m_wdata = cmd.value;
			end
			bsa_pkg::ST_CLEAR: m_we = 1'b1;
			bsa_pkg::ST_SCORE: mac_en = (k_q < nobj_e);
			bsa_pkg::ST_WRITE: s_we = 1'b1;
			bsa_pkg::ST_WSCAN, bsa_pkg::ST_RSCAN: map_idx = PW'(scan_i_q);
			bsa_pkg::ST_SHIFT: map_idx = worst_q;
			bsa_pkg::ST_RADDR: map_idx = PW'(e_q);
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bsa_pkg::ST_IDLE;
			nobj_q   <= 3'd4;
			npar_q   <= 7'd64;
			for (int j = 0; j < 4; j++) begin
				w_q[j] <= 16'd256;
			end
			pos_q    <= '0;
			held_q   <= '0;
			for (int j = 0; j < ARCHIVE_LIMIT; j++) begin
				map_q[j] <= PW'(j);
			end
			clr_q    <= '0;
			k_q      <= '0;
			scan_i_q <= '0;
			v_s1     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					bsa_pkg::REG_NUM_OBJ:  nobj_q <= cfg_data[2:0];
					bsa_pkg::REG_NUM_PAR:  npar_q <= cfg_data[6:0];
					bsa_pkg::REG_WEIGHT_0: w_q[0] <= cfg_data;
					bsa_pkg::REG_WEIGHT_1: w_q[1] <= cfg_data;
					bsa_pkg::REG_WEIGHT_2: w_q[2] <= cfg_data;
					bsa_pkg::REG_WEIGHT_3: w_q[3] <= cfg_data;
					default: begin
					end
				endcase
			end
			if (ld) begin
				pos_q <= ld_last ? 10'd0 : pos_q + 10'd1;
			end
			clr_q    <= (state_q == bsa_pkg::ST_CLEAR) ? clr_next : clr_start;
			k_q      <= (state_q == bsa_pkg::ST_SCORE) ? k_q + 3'd1 : 3'd0;
			scan_i_q <= issue ? scan_i_q + HW'(1) : (in_scan ? scan_i_q : HW'(0));
			v_s1     <= issue;
			if (state_q == bsa_pkg::ST_WRITE) begin
				held_q <= held_q + HW'(1);
			end
			if (state_q == bsa_pkg::ST_SHIFT) begin
				// The evicted entry's storage goes to the end of the order.
				for (int j = 0; j < ARCHIVE_LIMIT - 1; j++) begin
					if (PW'(j) >= worst_q) begin
						map_q[j] <= map_q[j+1];
					end
				end
				map_q[ARCHIVE_LIMIT-1] <= map_rd;
				held_q <= HW'(ARCHIVE_LIMIT - 1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= scan_i_q;
		if (ld && ld_is_obj) begin
			obj_q[OIW'(pos_q)] <= cmd.value;
		end
		if (ld && ld_last) begin
			phys_q       <= map_rd;
			read_value_q <= '0;
			read_error_q <= 1'b0;
			removed_q    <= 1'b0;
			removed_at_q <= '0;
		end
		if (rd) begin
			e_q          <= cmd.entry;
			slot_q       <= rd_slot;
			read_value_q <= '0;
			read_error_q <= rd_err;
			removed_q    <= 1'b0;
			removed_at_q <= '0;
		end
		if (state_q == bsa_pkg::ST_RDATA) begin
			read_value_q <= m_rdata;
		end
		if (state_q == bsa_pkg::ST_SHIFT) begin
			removed_q    <= 1'b1;
			removed_at_q <= 5'(worst_q);
		end
		if (state_q == bsa_pkg::ST_WSCAN && v_s1) begin
			if (idx_s1 == '0 || s_rdata > ws_q) begin
				ws_q    <= s_rdata;
				worst_q <= PW'(idx_s1);
			end
		end
		if (state_q == bsa_pkg::ST_RSCAN) begin
			if (!v_s1 && scan_i_q == '0) begin
				bs_q   <= bsa_pkg::SCORE_MAX;
				best_q <= '0;
				for (int k = 0; k < bsa_pkg::NUM_OBJ_OUT; k++) begin
					bo_q[k] <= '0;
				end
			end else if (v_s1) begin
				if (idx_s1 == '0 || s_rdata < bs_q) begin
					bs_q   <= s_rdata;
					best_q <= idx_s1;
				end
				for (int k = 0; k < MAX_OBJECTIVES; k++) begin
					if (k < 32'(nobj_e)) begin
						if (idx_s1 == '0 || $signed(o_rdata[k*32 +: 32]) < bv_q[k]) begin
							bv_q[k] <= $signed(o_rdata[k*32 +: 32]);
							bo_q[k] <= idx_s1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		result.read_value = read_value_q;
		result.read_error = read_error_q;
		result.best_all   = 5'(best_q);
		result.best_score = bs_q;
		result.best_obj_a = 5'(bo_q[0]);
		result.best_obj_b = 5'(bo_q[1]);
		result.best_obj_c = 5'(bo_q[2]);
		result.best_obj_d = 5'(bo_q[3]);
		result.held       = 5'(held_q);
		result.removed    = removed_q;
		result.removed_at = removed_at_q;
	end

endmodule

/* hdl/bsa_ram.sv */
module bsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/bsa_mac.sv */
module bsa_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clr,
	input  logic               en,
	input  logic [15:0]        weight,
	input  logic signed [31:0] operand,
	output logic [39:0]        score
);

	logic [46:0] prod_s1;
	logic        pv_s1;
	logic [49:0] acc_q;
	logic [41:0] shifted;

	// Negative objectives count as zero.
	always_ff @(posedge clk) begin
		prod_s1 <= operand[31] ? 47'd0 : 47'(weight) * 47'(operand[30:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else if (clr) begin
			pv_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			pv_s1 <= en;
			if (pv_s1) begin
				acc_q <= acc_q + 50'(prod_s1);
			end
		end
	end

	assign shifted = acc_q[49:8];
	assign score   = (shifted[41:40] != 2'b00) ? bsa_pkg::SCORE_MAX : shifted[39:0];

endmodule

/* test/bounded_scored_archive_tb.sv */
module bounded_scored_archive_tb;
	import bsa_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = ARCHIVE_LIMIT_DEF;
	localparam int N_OBJ   = MAX_OBJECTIVES_DEF;
	localparam int N_PAR   = MAX_PARAMS_DEF;
	localparam int SLOTS   = N_OBJ + N_PAR;
	localparam int SETTLE_CYCLES = 200;
	localparam int STALL_LIMIT   = 5000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	cmd_t        cmd = '0;
	logic        done;
	result_t     result;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	bounded_scored_archive u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow copy of the archive and its registers.
	logic [31:0] arc_mem [ENTRIES][SLOTS];
	logic [39:0] arc_score [ENTRIES];
	int unsigned arc_held = 0;
	int unsigned arc_pos = 0;
	logic [2:0]  cfg_nobj = 3'd4;
	logic [6:0]  cfg_npar = 7'd64;
	logic [15:0] cfg_w [4] = '{16'd256, 16'd256, 16'd256, 16'd256};

	cmd_t    pending_items[$];
	result_t expected_results[$];
	int      sender_idle_pct = 20;
	int      n_loads = 0, n_reads = 0, n_results = 0, n_evictions = 0, n_errors = 0;
	int      stall_count = 0;
	logic    accepted_now;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned active_objs();
		return (cfg_nobj < 1) ? 1 : (cfg_nobj > N_OBJ) ? N_OBJ : cfg_nobj;
	endfunction

	function automatic int unsigned active_params();
		return (cfg_npar < 1) ? 1 : (cfg_npar > N_PAR) ? N_PAR : cfg_npar;
	endfunction

	task automatic report_best(inout result_t r);
		int unsigned no;
		logic [39:0] bs;
		logic signed [31:0] bv [4];
		logic [4:0] bo [4];
		no = active_objs();
		bs = SCORE_MAX;
		r.best_all = '0;
		for (int k = 0; k < 4; k++) begin
			bo[k] = '0;
			bv[k] = '0;
		end
		for (int i = 0; i < arc_held; i++) begin
			if (i == 0 || arc_score[i] < bs) begin
				bs = arc_score[i];
				r.best_all = i[4:0];
			end
			for (int k = 0; k < no; k++)
				if (i == 0 || $signed(arc_mem[i][k]) < bv[k]) begin
					bv[k] = $signed(arc_mem[i][k]);
					bo[k] = i[4:0];
				end
		end
		r.best_score = bs;
		r.best_obj_a = bo[0];
		r.best_obj_b = bo[1];
		r.best_obj_c = bo[2];
		r.best_obj_d = bo[3];
		r.held = arc_held[4:0];
	endtask

	task automatic predict_item(input cmd_t c);
		int unsigned no, np, total, slot, worst;
		logic [63:0] sum;
		result_t r;
		no = active_objs();
		np = active_params();
		total = no + np;
		r = '0;
		if (c.func == FUNC_READ) begin
			if (c.entry >= arc_held || c.element >= total) begin
				r.read_error = 1'b1;
			end else begin
				slot = (c.element < no) ? c.element : N_OBJ + (c.element - no);
				r.read_value = arc_mem[c.entry][slot];
			end
			report_best(r);
			expected_results.push_back(r);
			return;
		end
		if (arc_pos < no)
			arc_mem[arc_held][arc_pos] = c.value;
		else if (arc_pos - no < N_PAR)
			arc_mem[arc_held][N_OBJ + arc_pos - no] = c.value;
		if (arc_pos + 1 < total) begin
			arc_pos = (arc_pos + 1) & 127;
			return;
		end
		arc_pos = 0;
		for (int i = no; i < N_OBJ; i++)
			arc_mem[arc_held][i] = '0;
		for (int i = np; i < N_PAR; i++)
			arc_mem[arc_held][N_OBJ + i] = '0;
		// Negative objectives add nothing; the Q24.24 sum drops to Q24.16.
		sum = '0;
		for (int i = 0; i < no; i++)
			if (!arc_mem[arc_held][i][31])
				sum += 64'(cfg_w[i]) * 64'(arc_mem[arc_held][i]);
		sum = sum >> 8;
		arc_score[arc_held] = (sum > 64'(SCORE_MAX)) ? SCORE_MAX : sum[39:0];
		arc_held++;
		if (arc_held >= ENTRIES) begin
			worst = 0;
			for (int i = 1; i < arc_held; i++)
				if (arc_score[i] > arc_score[worst])
					worst = i;
			for (int i = worst; i + 1 < arc_held; i++) begin
				arc_mem[i] = arc_mem[i + 1];
				arc_score[i] = arc_score[i + 1];
			end
			arc_held--;
			r.removed = 1'b1;
			r.removed_at = worst[4:0];
		end
		report_best(r);
		expected_results.push_back(r);
	endtask

	// Sender: an item is held on cmd until the block takes it.
	always @(posedge clk) begin
		accepted_now = arst_n && start && !busy;
		if (accepted_now) begin
			predict_item(cmd);
			if (cmd.func == FUNC_READ)
				n_reads++;
			else
				n_loads++;
		end
		if (arst_n && (!start || accepted_now)) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				cmd <= pending_items.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [39:0] want, input logic [39:0] got);
		if (want !== got) begin
			$display("%0t: mismatch on %s: expected %h, actual %h", $time, name, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin : result_monitor
		result_t want;
		if (arst_n && done) begin
			n_results++;
			if (result.removed === 1'b1)
				n_evictions++;
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: expected nothing, actual %h",
					$time, result);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("read_value", 40'(want.read_value), 40'(result.read_value));
				check_field("read_error", 40'(want.read_error), 40'(result.read_error));
				check_field("best_all", 40'(want.best_all), 40'(result.best_all));
				check_field("best_score", want.best_score, result.best_score);
				check_field("best_obj_a", 40'(want.best_obj_a), 40'(result.best_obj_a));
				check_field("best_obj_b", 40'(want.best_obj_b), 40'(result.best_obj_b));
				check_field("best_obj_c", 40'(want.best_obj_c), 40'(result.best_obj_c));
				check_field("best_obj_d", 40'(want.best_obj_d), 40'(result.best_obj_d));
				check_field("held", 40'(want.held), 40'(result.held));
				check_field("removed", 40'(want.removed), 40'(result.removed));
				check_field("removed_at", 40'(want.removed_at), 40'(result.removed_at));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_NUM_OBJ: cfg_nobj = data[2:0];
			REG_NUM_PAR: cfg_npar = data[6:0];
			REG_WEIGHT_0, REG_WEIGHT_1, REG_WEIGHT_2, REG_WEIGHT_3:
				cfg_w[idx - REG_WEIGHT_0] = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int nobj, input int npar, input logic [15:0] w0,
			input logic [15:0] w1, input logic [15:0] w2, input logic [15:0] w3);
		write_reg(REG_NUM_OBJ, 16'(nobj));
		write_reg(REG_NUM_PAR, 16'(npar));
		write_reg(REG_WEIGHT_0, w0);
		write_reg(REG_WEIGHT_1, w1);
		write_reg(REG_WEIGHT_2, w2);
		write_reg(REG_WEIGHT_3, w3);
		// An index past the register list must be ignored.
		write_reg(3'($urandom_range(6, 7)), 16'($urandom));
	endtask

	// Also used as the pause in which the sender waits for every result.
	task automatic wait_idle();
		wait (pending_items.size() == 0 && !start && expected_results.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_load(input logic [31:0] v);
		cmd_t c;
		c = '0;
		c.func = FUNC_LOAD;
		c.value = v;
		c.entry = 5'($urandom);
		c.element = 7'($urandom);
		pending_items.push_back(c);
	endtask

	task automatic push_read(input int e, input int el);
		cmd_t c;
		c.func = FUNC_READ;
		c.value = $urandom;
		c.entry = 5'(e);
		c.element = 7'(el);
		pending_items.push_back(c);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(32'h3_0000));
			3: return -32'($urandom_range(32'h3_0000));
			4: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(3))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_random_items(input int count);
		int n, total, r;
		n = 0;
		total = active_objs() + active_params();
		while (n < count) begin
			r = $urandom_range(9);
			if (r < 7) begin
				for (int i = 0; i < total; i++)
					push_load(pick_value());
				n += total;
			end else if (r < 9) begin
				if ($urandom_range(3) == 0)
					push_read($urandom_range(31), $urandom_range(127));
				else
					push_read($urandom_range(31), $urandom_range(total + 1));
				n++;
			end else begin
				push_load(pick_value());
				n++;
			end
		end
	endtask

	initial begin
		int pct [3];
		pct = '{20, 76, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty archive, then a full-width candidate finished after a change of
		// objective count, so that its last parameter falls beyond the slots.
		push_read(0, 0);
		for (int i = 0; i < 67; i++)
			push_load(pick_value());
		wait_idle();
		write_reg(REG_NUM_OBJ, 16'd1);
		push_load(32'h1234_5678);
		push_read(0, 0);
		push_read(0, 64);
		push_read(0, 65);
		wait_idle();

		set_config(4, 2, 16'd256, 16'hFFFF, 16'd0, 16'd1);
		push_load(32'h7FFF_FFFF);
		push_load(32'h8000_0000);
		push_load(32'h0);
		push_load(32'h1);
		push_load(32'hFFFF_FFFF);
		push_load(32'h0001_0000);
		for (int i = 0; i < 6; i++)
			push_load('0);
		push_read(1, 0);
		push_read(1, 5);
		push_read(1, 6);
		push_read(31, 0);
		push_read(2, 0);
		push_read(0, 127);
		wait_idle();

		for (int ph = 0; ph < 3; ph++) begin
			sender_idle_pct = pct[ph];
			for (int blk = 0; blk < 3; blk++) begin
				if ($urandom_range(3) == 0)
					set_config($urandom_range(7), $urandom_range(4) == 0 ? 127 : 64,
						pick_weight(), pick_weight(), pick_weight(), pick_weight());
				else
					set_config($urandom_range(7), $urandom_range(3),
						pick_weight(), pick_weight(), pick_weight(), pick_weight());
				push_random_items(50);
				wait_idle();
			end
		end

		$display("%0d loads and %0d reads accepted, %0d results checked, %0d evictions.",
			n_loads, n_reads, n_results, n_evictions);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* bounded_scored_archive.f */
hdl/bsa_pkg.sv
hdl/bsa_ram.sv
hdl/bsa_mac.sv
hdl/bounded_scored_archive.sv
test/bounded_scored_archive_tb.sv
